### rtl/rlse_pkg.sv
`timescale 1ns / 1ps

package rlse_pkg;

   // Item kinds carried on req_tuser
   localparam logic CMD_SET  = 1'b0;
   localparam logic CMD_SEND = 1'b1;

   // Line bytes per LED: 24 color bits x 3 line bits / 8
   localparam int unsigned COLOR_BITS    = 24;
   localparam int unsigned LINE_BITS     = COLOR_BITS * 3;
   localparam int unsigned BYTES_PER_LED = LINE_BITS / 8;
   localparam logic [3:0]  LAST_BYTE     = 4'(BYTES_PER_LED - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_wr;   // write zero at the sweep address
      logic set_wr;   // store the color of the accepted set beat
      logic rd_en;    // read the LED at the send position
      logic load;     // load the output register and advance
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;  // sweep is at the last entry
      logic out_stall; // output register holds a beat not yet taken
   } status_type;

   // Each color bit becomes 1,c,0 on the line, MSB first
   function automatic logic [LINE_BITS-1:0] rlse_expand(input logic [COLOR_BITS-1:0] color);
      logic [LINE_BITS-1:0] line;
      line = '0;
      for (int i = 0; i < COLOR_BITS; i++) begin
         line[3*i +: 3] = {1'b1, color[i], 1'b0};
      end
      return line;
   endfunction

   // One byte of the line pattern, byte 0 holds the first line bits
   function automatic logic [7:0] rlse_byte(input logic [COLOR_BITS-1:0] color,
                                            input logic [3:0] byte_no);
      logic [LINE_BITS-1:0] line;
      logic [7:0]           res;
      line = rlse_expand(color);
      unique case (byte_no)
         4'd0:    res = line[71:64];
         4'd1:    res = line[63:56];
         4'd2:    res = line[55:48];
         4'd3:    res = line[47:40];
         4'd4:    res = line[39:32];
         4'd5:    res = line[31:24];
         4'd6:    res = line[23:16];
         4'd7:    res = line[15:8];
         4'd8:    res = line[7:0];
         default: res = 8'h00;
      endcase
      return res;
   endfunction

endpackage

### rtl/rlse_ctrl.sv
`timescale 1ns / 1ps

module rlse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tuser,
   output logic                req_tready,
   input  rlse_pkg::status_type status,
   output rlse_pkg::cmd_type    cmd
);
   import rlse_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid && req_tuser == CMD_SEND) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!status.out_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.set_wr = req_tvalid && req_tuser == CMD_SET;
            cmd.rd_en  = req_tvalid && req_tuser == CMD_SEND;
         end
         ST_LOAD: begin
            cmd.load = !status.out_stall;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/rlse_dp.sv
`timescale 1ns / 1ps

module rlse_dp #(
   parameter int LED_COUNT = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [39:0]         req_tdata,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  rlse_pkg::cmd_type    cmd,
   output rlse_pkg::status_type status
);
   import rlse_pkg::*;

   localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int PW = $clog2(LED_COUNT + 1);
   localparam logic [10:0]   COUNT_W  = 11'(LED_COUNT);
   localparam logic [PW-1:0] TRAILER  = PW'(LED_COUNT);
   localparam logic [AW-1:0] CLR_LAST = AW'(LED_COUNT - 1);

   // Entry: written mark over green, red, blue
   logic [COLOR_BITS:0] mem [LED_COUNT];
   logic [COLOR_BITS:0] rd_ff;

   logic [AW-1:0] clr_ff;
   logic [AW-1:0] clr_in;
   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic [3:0]    byte_ff;
   logic [3:0]    byte_in;
   logic          valid_ff;
   logic          valid_in;
   logic [7:0]    data_ff;
   logic [7:0]    data_in;
   logic          last_ff;
   logic          last_in;

   logic [9:0]  in_index;
   logic [7:0]  in_red;
   logic [7:0]  in_green;
   logic [7:0]  in_blue;
   logic        in_range;
   logic        trailer;

   assign in_index = req_tdata[9:0];
   assign in_red   = req_tdata[17:10];
   assign in_green = req_tdata[25:18];
   assign in_blue  = req_tdata[33:26];
   assign in_range = {1'b0, in_index} < COUNT_W;
   assign trailer  = pos_ff == TRAILER;

   // Color store: clear sweep or set write, registered read
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         mem[clr_ff] <= '0;
      end else if (cmd.set_wr && in_range) begin
         mem[in_index[AW-1:0]] <= {1'b1, in_green, in_red, in_blue};
      end
      if (cmd.rd_en && !trailer) begin
         rd_ff <= mem[pos_ff[AW-1:0]];
      end
   end

   // Sweep address
   assign clr_in = cmd.clr_wr ? clr_ff + 1'b1 : clr_ff;

   // Frame position and output beat
   always_comb begin
      pos_in   = pos_ff;
      byte_in  = byte_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;
      if (cmd.load) begin
         valid_in = 1'b1;
         if (trailer) begin
            data_in = 8'h00;
            last_in = 1'b1;
            pos_in  = '0;
            byte_in = '0;
         end else begin
            data_in = rd_ff[COLOR_BITS] ? rlse_byte(rd_ff[COLOR_BITS-1:0], byte_ff) : 8'h00;
            last_in = 1'b0;
            if (byte_ff == LAST_BYTE) begin
               byte_in = '0;
               pos_in  = pos_ff + 1'b1;
            end else begin
               byte_in = byte_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         pos_ff   <= '0;
         byte_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         clr_ff   <= clr_in;
         pos_ff   <= pos_in;
         byte_ff  <= byte_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tvalid = valid_ff;

   assign status.clr_last  = clr_ff == CLR_LAST;
   assign status.out_stall = valid_ff && !rsp_tready;

endmodule

### rtl/rgb_led_strip_spi_encoder.sv
`timescale 1ns / 1ps

// LED strip color store and SPI frame encoder.
// Input channel (req_*): req_tuser selects the beat kind. A set beat writes
// one LED color (green, red, blue) and marks it written; an index at or
// beyond LED_COUNT is dropped. A send beat asks for the next SPI byte.
// Result channel (rsp_*): one byte per send beat. Each color bit goes out
// MSB first as three line bits, 110 for one and 100 for zero, so an LED is
// 9 bytes; a never-written LED sends 9 zero bytes. After LED_COUNT LEDs a
// zero byte with rsp_tlast high ends the frame and the position wraps.
// Timing: a set beat is taken every cycle while idle. A send beat reads
// the color store through its single registered read port, then its byte
// is loaded into the output register; no beat is taken until then.
// Reset: a sweep clears all LED_COUNT store entries, one entry per
// cycle, during which req_tready stays low. Frame position returns to LED 0.
// Stall: the output register holds its beat while rsp_tready is low; set
// beats and one send are still taken, then req_tready stays low until that
// send's byte is loaded into the freed register.
module rgb_led_strip_spi_encoder #(
   parameter int LED_COUNT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // led_index[9:0], red[17:10], green[25:18], blue[33:26]
   input  logic        req_tuser,  // cmd: 0 set LED, 1 send byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // spi_byte[7:0]
   output logic        rsp_tlast   // frame_last
);
   import rlse_pkg::*;

   cmd_type    cmd;
   status_type status;

   rlse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rlse_dp #(
      .LED_COUNT (LED_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Frame end beat is always a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == 8'h00)
      else $error("frame end beat carries nonzero data");

   // A pending output beat is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !cmd.load)
      else $error("output register loaded while stalled");

   // An accepted send blocks the input until its byte is loaded
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_SEND |=> !req_tready)
      else $error("input taken while a send is in flight");

endmodule
